// ===== sv/insertion_sorter_macros.svh =====
// assertion macros for the insertion sorter
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ISORT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ISORT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/isort_pkg.sv =====
// shared constants and types of the insertion sorter
package isort_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 16;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic ins;        // insert the broadcast value this cycle
		logic emit;       // shift the whole chain one cell toward the head
		logic descending; // sort order
	} isort_ctl_t;

endpackage

// ===== sv/isort_cell.sv =====
// one compare-and-shift cell of the sorting chain
module isort_cell #(
	parameter int DATA_WIDTH = isort_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  isort_pkg::isort_ctl_t ctl,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  prev_valid,
	input  logic                  prev_after,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic                  next_valid,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic                  valid,
	output logic                  after,
	output logic [DATA_WIDTH-1:0] data
);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;

	// new value belongs behind this entry
	assign after = valid_q && (ctl.descending ? (value < data_q) : (value > data_q));
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.emit) begin
			valid_q <= next_valid;
		end else if (ctl.ins && !after) begin
			valid_q <= prev_after ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			data_q <= next_data;
		end else if (ctl.ins && !after) begin
			data_q <= prev_after ? value : prev_data;
		end
	end

endmodule

// ===== sv/insertion_sorter.sv =====
// insertion sorter: an item is taken each cycle while the chain is not emitting
// an item is inserted when it transfers unless the chain is full; a last transfer
// starts emission, then results follow one per cycle while res_stall is low
// input is stalled while the chain shifts its stored entries out
// reset empties the chain, clears the overflow flag and selects ascending order
`include "insertion_sorter_macros.svh"

module insertion_sorter #(
	parameter int DEPTH      = isort_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = isort_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  last,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [DATA_WIDTH-1:0] value_res,
	output logic                  last_res,
	output logic                  overflowed
);

	logic                  descending_q;
	logic                  emit_q;
	logic                  ovf_q;
	logic                  res_valid_q;
	logic [DATA_WIDTH-1:0] value_res_q;
	logic                  last_res_q;
	logic                  overflowed_q;

	logic                  in_xfer;
	logic                  emit_go;
	logic                  full;
	isort_pkg::isort_ctl_t ctl;

	logic [DEPTH-1:0]      cell_valid;
	logic [DEPTH-1:0]      cell_after;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign item_stall = emit_q;
	assign in_xfer    = item_valid && !emit_q;
	assign full       = cell_valid[DEPTH-1];
	assign emit_go    = emit_q && (!res_valid_q || !res_stall);

	assign ctl.ins        = in_xfer && !full;
	assign ctl.emit       = emit_go;
	assign ctl.descending = descending_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  pv;
		logic                  pa;
		logic [DATA_WIDTH-1:0] pd;
		logic                  nv;
		logic [DATA_WIDTH-1:0] nd;

		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pa = 1'b1;
			assign pd = '0;
		end else begin : g_body
			assign pv = cell_valid[i-1];
			assign pa = cell_after[i-1];
			assign pd = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign nv = 1'b0;
			assign nd = '0;
		end else begin : g_inner
			assign nv = cell_valid[i+1];
			assign nd = cell_data[i+1];
		end

		isort_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.value     (value),
			.prev_valid(pv),
			.prev_after(pa),
			.prev_data (pd),
			.next_valid(nv),
			.next_data (nd),
			.valid     (cell_valid[i]),
			.after     (cell_after[i]),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_we) begin
			descending_q <= cfg_wdata;
		end
	end

	// emission runs until the entry that goes out has no successor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (emit_go) begin
			if (!cell_valid[1]) begin
				emit_q <= 1'b0;
				ovf_q  <= 1'b0;
			end
		end else if (in_xfer) begin
			if (full) begin
				ovf_q <= 1'b1;
			end
			if (last) begin
				emit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			value_res_q  <= cell_data[0];
			last_res_q   <= !cell_valid[1];
			overflowed_q <= ovf_q;
		end
	end

	assign res_valid  = res_valid_q;
	assign value_res  = value_res_q;
	assign last_res   = last_res_q;
	assign overflowed = overflowed_q;

	`ISORT_ASSERT_IMP(a_emit_nonempty, emit_q, cell_valid[0], "emitting from an empty chain")
	`ISORT_ASSERT_IMP(a_valid_prefix, 1'b1, (cell_valid & (cell_valid + DEPTH'(1))) == '0, "chain has a hole")
	`ISORT_ASSERT_NXT(a_last_emits, in_xfer && last, emit_q, "last transfer did not start emission")
	`ISORT_ASSERT_IMP(a_end_shown, $fell(emit_q), res_valid && last_res, "emission ended without final result")

endmodule
